/* sv/rmq_pkg.sv */
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared widths, constants and payload types of the rotation matrix to
// quaternion pipeline.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int ElemW     = 18;   // Q1.16 matrix element and result
    localparam int TsW       = 64;
    localparam int TolW      = 32;
    localparam int CompW     = 21;   // unnormalized quaternion component
    localparam int SumW      = 40;   // sum of four squared components
    localparam int RootInW   = 64;
    localparam int RootSteps = 32;
    localparam int SqrtShift = 22;
    localparam int DenW      = 32;
    localparam int NumW      = 48;
    localparam int FracShift = 27;
    localparam int QuoW      = 19;

    localparam int InDataW   = 232;  // 9 elements + timestamp, byte padded
    localparam int OutDataW  = 136;

    localparam logic [TolW-1:0]  TolReset = 32'd4295;
    localparam logic [QuoW-1:0]  PosMax   = 19'd131071;
    localparam logic [QuoW-1:0]  NegMax   = 19'd131072;

    typedef logic signed [ElemW-1:0] elem_t;
    typedef logic signed [CompW-1:0] comp_t;

    localparam comp_t QOne = 21'sd65536;

    typedef struct packed {
        elem_t m00; elem_t m01; elem_t m02;
        elem_t m10; elem_t m11; elem_t m12;
        elem_t m20; elem_t m21; elem_t m22;
    } mat_t;

    typedef struct packed {
        logic           ok;
        comp_t          w;
        comp_t          x;
        comp_t          y;
        comp_t          z;
        logic [TsW-1:0] ts;
    } conv_t;

    typedef struct packed {
        logic           ok;
        elem_t          w;
        elem_t          x;
        elem_t          y;
        elem_t          z;
        logic [TsW-1:0] ts;
    } res_t;

endpackage

/* sv/rotation_matrix_to_quaternion.sv */
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Checks a Q1.16 rotation matrix and converts it to a normalized quaternion.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one request carries the nine matrix elements and a timestamp.
//   m_ channel: one result per request; m_tuser is the valid flag, m_tdata
//   holds the quaternion (zero when the matrix is rejected) and timestamp.
//   cfg channel: writes the tolerance register, ready whenever out of reset;
//   write it only while no request is in flight.
// Throughput: one request per cycle unless the output stalls (see Stall). The
//   pipeline depth is set by the 32-step square root and the 19-step divider,
//   one step per stage, plus the check stages and the input and output registers.
// Reset: clears all stage valid bits and the output valid flag, loads the
//   tolerance with 4295 and holds s_tready and cfg_ready low.
// Stall: while a result waits with m_tready low the whole pipeline holds and
//   s_tready drops; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, timestamp, zero pad
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // quat_w, quat_x, quat_y, quat_z, time_out
    output logic [OutDataW-1:0] m_tdata,
    // is_valid
    output logic                m_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TolW-1:0]     cfg_data
);

    logic [TolW-1:0] tolerance_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= TolReset;
        end else if (cfg_valid && cfg_ready) begin
            tolerance_reg <= cfg_data;
        end
    end

    logic en;
    logic m_tvalid_reg;

    // whole pipeline moves together whenever the output register can load
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = aresetn && en;

    mat_t in_mat;

    assign in_mat.m00 = s_tdata[0*ElemW +: ElemW];
    assign in_mat.m01 = s_tdata[1*ElemW +: ElemW];
    assign in_mat.m02 = s_tdata[2*ElemW +: ElemW];
    assign in_mat.m10 = s_tdata[3*ElemW +: ElemW];
    assign in_mat.m11 = s_tdata[4*ElemW +: ElemW];
    assign in_mat.m12 = s_tdata[5*ElemW +: ElemW];
    assign in_mat.m20 = s_tdata[6*ElemW +: ElemW];
    assign in_mat.m21 = s_tdata[7*ElemW +: ElemW];
    assign in_mat.m22 = s_tdata[8*ElemW +: ElemW];

    logic            chk_valid;
    conv_t           chk_conv;
    logic [SumW-1:0] chk_sum;

    rmq_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_mat    (in_mat),
        .in_ts     (s_tdata[9*ElemW +: TsW]),
        .tolerance (tolerance_reg),
        .out_valid (chk_valid),
        .out_conv  (chk_conv),
        .out_sum   (chk_sum)
    );

    logic            sq_valid;
    conv_t           sq_conv;
    logic [DenW-1:0] sq_den;

    rmq_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chk_valid),
        .in_conv   (chk_conv),
        .in_sum    (chk_sum),
        .out_valid (sq_valid),
        .out_conv  (sq_conv),
        .out_den   (sq_den)
    );

    logic div_valid;
    res_t div_res;

    rmq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_conv   (sq_conv),
        .in_den    (sq_den),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    logic [OutDataW-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {div_res.ts, div_res.z, div_res.y, div_res.x, div_res.w};
            m_tuser_reg <= div_res.ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* sv/rmq_check.sv */
// ---------------------------------------------------------------------------
// rmq_check
// Four-stage rotation test (column norms, orthogonality, determinant) and
// four-branch quaternion selection; emits the raw quaternion and its squared
// sum.
// ---------------------------------------------------------------------------
module rmq_check
    import rmq_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  mat_t            in_mat,
    input  logic [TsW-1:0]  in_ts,
    input  logic [TolW-1:0] tolerance,
    output logic            out_valid,
    output conv_t           out_conv,
    output logic [SumW-1:0] out_sum
);

    elem_t m [0:2][0:2];

    assign m[0][0] = in_mat.m00;
    assign m[0][1] = in_mat.m01;
    assign m[0][2] = in_mat.m02;
    assign m[1][0] = in_mat.m10;
    assign m[1][1] = in_mat.m11;
    assign m[1][2] = in_mat.m12;
    assign m[2][0] = in_mat.m20;
    assign m[2][1] = in_mat.m21;
    assign m[2][2] = in_mat.m22;

    // ---------------- stage a: products, branch select
    logic signed [19:0] tr;
    comp_t              qa [0:3];
    comp_t              lead;

    always_comb begin
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            lead  = QOne + tr;
            qa[0] = lead;
            qa[1] = m[2][1] - m[1][2];
            qa[2] = m[0][2] - m[2][0];
            qa[3] = m[1][0] - m[0][1];
        end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
            lead  = QOne + m[0][0] - m[1][1] - m[2][2];
            qa[0] = m[2][1] - m[1][2];
            qa[1] = lead;
            qa[2] = m[0][1] + m[1][0];
            qa[3] = m[0][2] + m[2][0];
        end else if (m[1][1] > m[2][2]) begin
            lead  = QOne + m[1][1] - m[0][0] - m[2][2];
            qa[0] = m[0][2] - m[2][0];
            qa[1] = m[0][1] + m[1][0];
            qa[2] = lead;
            qa[3] = m[1][2] + m[2][1];
        end else begin
            lead  = QOne + m[2][2] - m[0][0] - m[1][1];
            qa[0] = m[1][0] - m[0][1];
            qa[1] = m[0][2] + m[2][0];
            qa[2] = m[1][2] + m[2][1];
            qa[3] = lead;
        end
    end

    logic               va_reg;
    logic signed [35:0] sq_reg [0:8];
    logic signed [35:0] dp_reg [0:8];
    logic signed [35:0] cf_reg [0:5];
    elem_t              row_a_reg [0:2];
    comp_t              qa_reg [0:3];
    logic               lead_a_reg;
    logic [TsW-1:0]     ts_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    sq_reg[3*r+c] <= m[r][c] * m[r][c];
                end
                dp_reg[r]     <= m[r][0] * m[r][1];
                dp_reg[3 + r] <= m[r][0] * m[r][2];
                dp_reg[6 + r] <= m[r][1] * m[r][2];
                row_a_reg[r]  <= m[0][r];
            end
            cf_reg[0] <= m[1][1] * m[2][2];
            cf_reg[1] <= m[1][2] * m[2][1];
            cf_reg[2] <= m[1][0] * m[2][2];
            cf_reg[3] <= m[1][2] * m[2][0];
            cf_reg[4] <= m[1][0] * m[2][1];
            cf_reg[5] <= m[1][1] * m[2][0];
            for (int k = 0; k < 4; k++) begin
                qa_reg[k] <= qa[k];
            end
            lead_a_reg <= (lead > 0);
            ts_a_reg   <= in_ts;
        end
    end

    // ---------------- stage b: norms, dots, cofactors, component squares
    logic               vb_reg;
    logic signed [37:0] norm_reg [0:2];
    logic signed [37:0] dot_reg [0:2];
    logic signed [36:0] cof_reg [0:2];
    logic [37:0]        qsq_reg [0:3];
    elem_t              row_b_reg [0:2];
    comp_t              qb_reg [0:3];
    logic               lead_b_reg;
    logic [TsW-1:0]     ts_b_reg;
    logic signed [41:0] qprod [0:3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            qprod[k] = qa_reg[k] * qa_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                norm_reg[c] <= 38'(sq_reg[c]) + 38'(sq_reg[3+c]) + 38'(sq_reg[6+c]);
                dot_reg[c]  <= 38'(dp_reg[3*c]) + 38'(dp_reg[3*c+1]) + 38'(dp_reg[3*c+2]);
                cof_reg[c]  <= 37'(cf_reg[2*c]) - 37'(cf_reg[2*c+1]);
                row_b_reg[c] <= row_a_reg[c];
            end
            for (int k = 0; k < 4; k++) begin
                qsq_reg[k] <= qprod[k][37:0];
                qb_reg[k]  <= qa_reg[k];
            end
            lead_b_reg <= lead_a_reg;
            ts_b_reg   <= ts_a_reg;
        end
    end

    // ---------------- stage c: norm and dot tests, determinant products
    logic signed [39:0] tol_s;
    logic signed [39:0] ndiff [0:2];
    logic signed [39:0] dext [0:2];
    logic               fail_c;

    assign tol_s = $signed({8'd0, tolerance});

    always_comb begin
        fail_c = 1'b0;
        for (int c = 0; c < 3; c++) begin
            ndiff[c] = 40'(norm_reg[c]) - (40'sd1 <<< 32);
            dext[c]  = 40'(dot_reg[c]);
            if (ndiff[c] > tol_s || ndiff[c] < -tol_s) begin
                fail_c = 1'b1;
            end
            if (dext[c] > tol_s || dext[c] < -tol_s) begin
                fail_c = 1'b1;
            end
        end
    end

    logic               vc_reg;
    logic               fail_c_reg;
    logic signed [54:0] detp_reg [0:2];
    logic [SumW-1:0]    sum_c_reg;
    comp_t              qc_reg [0:3];
    logic               lead_c_reg;
    logic [TsW-1:0]     ts_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fail_c_reg <= fail_c;
            for (int c = 0; c < 3; c++) begin
                detp_reg[c] <= row_b_reg[c] * cof_reg[c];
            end
            sum_c_reg <= SumW'(qsq_reg[0]) + SumW'(qsq_reg[1])
                       + SumW'(qsq_reg[2]) + SumW'(qsq_reg[3]);
            for (int k = 0; k < 4; k++) begin
                qc_reg[k] <= qb_reg[k];
            end
            lead_c_reg <= lead_b_reg;
            ts_c_reg   <= ts_b_reg;
        end
    end

    // ---------------- stage d: determinant test, final flag
    logic signed [58:0] det_dev;
    logic signed [58:0] tol_det;
    logic               det_ok;

    assign det_dev = 59'(detp_reg[0]) - 59'(detp_reg[1]) + 59'(detp_reg[2])
                   - (59'sd1 <<< 48);
    assign tol_det = $signed({11'd0, tolerance, 16'd0});
    assign det_ok  = (det_dev <= tol_det) && (det_dev >= -tol_det);

    logic            vd_reg;
    conv_t           conv_d_reg;
    logic [SumW-1:0] sum_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            conv_d_reg.ok <= !fail_c_reg && det_ok && lead_c_reg;
            conv_d_reg.w  <= qc_reg[0];
            conv_d_reg.x  <= qc_reg[1];
            conv_d_reg.y  <= qc_reg[2];
            conv_d_reg.z  <= qc_reg[3];
            conv_d_reg.ts <= ts_c_reg;
            sum_d_reg     <= sum_c_reg;
        end
    end

    assign out_valid = vd_reg;
    assign out_conv  = conv_d_reg;
    assign out_sum   = sum_d_reg;

endmodule

/* sv/rmq_sqrt.sv */
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root of sum * 2^22, one result bit per stage.
// ---------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  conv_t           in_conv,
    input  logic [SumW-1:0] in_sum,
    output logic            out_valid,
    output conv_t           out_conv,
    output logic [DenW-1:0] out_den
);

    logic [RootInW-1:0] rem_reg  [0:RootSteps];
    logic [RootInW-1:0] root_reg [0:RootSteps];
    conv_t              pay_reg  [0:RootSteps];
    logic [RootSteps:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[RootSteps-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {{(RootInW-SumW-SqrtShift){1'b0}}, in_sum, {SqrtShift{1'b0}}};
            root_reg[0] <= '0;
            pay_reg[0]  <= in_conv;
        end
    end

    for (genvar i = 0; i < RootSteps; i++) begin : g_step
        localparam logic [RootInW-1:0] Bit = RootInW'(1) << (2 * (RootSteps - 1 - i));
        logic [RootInW-1:0] trial;

        assign trial = root_reg[i] + Bit;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[i] >= trial) begin
                    rem_reg[i+1]  <= rem_reg[i] - trial;
                    root_reg[i+1] <= (root_reg[i] >> 1) + Bit;
                end else begin
                    rem_reg[i+1]  <= rem_reg[i];
                    root_reg[i+1] <= root_reg[i] >> 1;
                end
                pay_reg[i+1] <= pay_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[RootSteps];
    assign out_conv  = pay_reg[RootSteps];
    // zero root only for an empty sum; keep the divider defined
    assign out_den   = (root_reg[RootSteps] == '0) ? DenW'(1) : root_reg[RootSteps][DenW-1:0];

endmodule

/* sv/rmq_div.sv */
// ---------------------------------------------------------------------------
// rmq_div
// Four-lane pipelined restoring divider: |q| * 2^27 / den rounded half away
// from zero, then sign, saturation and zeroing of rejected matrices.
// ---------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  conv_t           in_conv,
    input  logic [DenW-1:0] in_den,
    output logic            out_valid,
    output res_t            out_res
);

    typedef struct packed {
        logic           ok;
        logic [3:0]     neg;
        logic [TsW-1:0] ts;
    } side_t;

    comp_t            qin [0:3];
    logic [CompW-1:0] mag [0:3];
    logic [NumW-1:0]  num [0:3];

    assign qin[0] = in_conv.w;
    assign qin[1] = in_conv.x;
    assign qin[2] = in_conv.y;
    assign qin[3] = in_conv.z;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            mag[l] = (qin[l] < 0) ? CompW'(-qin[l]) : CompW'(qin[l]);
            num[l] = (NumW'(mag[l]) << FracShift) + NumW'(in_den >> 1);
        end
    end

    logic [DenW:0]   rem_reg [0:QuoW][0:3];
    logic [QuoW-1:0] nlo_reg [0:QuoW][0:3];
    logic [QuoW-1:0] quo_reg [0:QuoW][0:3];
    logic [DenW-1:0] den_reg [0:QuoW];
    side_t           side_reg [0:QuoW];
    logic [QuoW+1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[QuoW:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                rem_reg[0][l] <= (DenW+1)'(num[l] >> QuoW);
                nlo_reg[0][l] <= num[l][QuoW-1:0];
                quo_reg[0][l] <= '0;
                side_reg[0].neg[l] <= (qin[l] < 0);
            end
            den_reg[0]     <= in_den;
            side_reg[0].ok <= in_conv.ok;
            side_reg[0].ts <= in_conv.ts;
        end
    end

    for (genvar j = 0; j < QuoW; j++) begin : g_bit
        logic [DenW:0] shifted [0:3];
        logic          take    [0:3];

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                shifted[l] = {rem_reg[j][l][DenW-1:0], nlo_reg[j][l][QuoW-1]};
                take[l]    = (shifted[l] >= {1'b0, den_reg[j]});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 4; l++) begin
                    rem_reg[j+1][l] <= take[l] ? shifted[l] - {1'b0, den_reg[j]}
                                               : shifted[l];
                    nlo_reg[j+1][l] <= nlo_reg[j][l] << 1;
                    quo_reg[j+1][l] <= {quo_reg[j][l][QuoW-2:0], take[l]};
                end
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    // sign and saturate
    elem_t           sat [0:3];
    logic [QuoW-1:0] lim [0:3];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (side_reg[QuoW].neg[l]) begin
                lim[l] = (quo_reg[QuoW][l] > NegMax) ? NegMax : quo_reg[QuoW][l];
                sat[l] = ElemW'(QuoW'(0) - lim[l]);
            end else begin
                lim[l] = (quo_reg[QuoW][l] > PosMax) ? PosMax : quo_reg[QuoW][l];
                sat[l] = ElemW'(lim[l]);
            end
        end
    end

    res_t res_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.ok <= side_reg[QuoW].ok;
            res_reg.w  <= side_reg[QuoW].ok ? sat[0] : '0;
            res_reg.x  <= side_reg[QuoW].ok ? sat[1] : '0;
            res_reg.y  <= side_reg[QuoW].ok ? sat[2] : '0;
            res_reg.z  <= side_reg[QuoW].ok ? sat[3] : '0;
            res_reg.ts <= side_reg[QuoW].ts;
        end
    end

    assign out_valid = valid_reg[QuoW+1];
    assign out_res   = res_reg;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the rotation matrix to quaternion converter: a
// directed stimulus table, then random rotations, signed permutations,
// perturbed and noise matrices under several tolerance settings and
// handshake pressures. Each result is checked against its table row's value
// or an in-bench predictor of the fixed-point conversion.
// ---------------------------------------------------------------------------
module tb;
    import rmq_pkg::*;

    localparam int LatencyWait = 70;
    localparam int RandomItems = 600;
    localparam int Phases      = 8;

    typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

    typedef struct {
        mat_t           mat;
        logic [TsW-1:0] ts;
        bit             typed;
        res_t           want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TolW-1:0]     cfg_data;

    res_t            pending_quats[$];
    stim_row_t       stim_rows[$];
    logic [TolW-1:0] tol_shadow;
    idle_mode_t      idle_mode;
    int              hold_request;
    int              error_count;

    rotation_matrix_to_quaternion i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic res_t predict_quaternion(input mat_t mt, input logic [TsW-1:0] ts,
                                                input logic [TolW-1:0] tol);
        longint m[3][3];
        longint q[4];
        longint n, d, c0, c1, c2, det, tr, lead, tl, comp;
        longint unsigned s, den, a, r;
        bit ok;
        res_t res;
        m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
        m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
        m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
        tl = longint'(tol);
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n = m[0][i] * m[0][i] + m[1][i] * m[1][i] + m[2][i] * m[2][i] - (64'sd1 << 32);
            if ((n < 0 ? -n : n) > tl) ok = 1'b0;
            for (int j = i + 1; j < 3; j++) begin
                d = m[0][i] * m[0][j] + m[1][i] * m[1][j] + m[2][i] * m[2][j];
                if ((d < 0 ? -d : d) > tl) ok = 1'b0;
            end
        end
        c0 = m[1][1] * m[2][2] - m[1][2] * m[2][1];
        c1 = m[1][0] * m[2][2] - m[1][2] * m[2][0];
        c2 = m[1][0] * m[2][1] - m[1][1] * m[2][0];
        det = m[0][0] * c0 - m[0][1] * c1 + m[0][2] * c2 - (64'sd1 << 48);
        if ((det < 0 ? -det : det) > (tl << 16)) ok = 1'b0;
        if (ok) begin
            tr = m[0][0] + m[1][1] + m[2][2];
            if (tr > 0) begin
                lead = 65536 + tr;
                q[0] = lead;                q[1] = m[2][1] - m[1][2];
                q[2] = m[0][2] - m[2][0];   q[3] = m[1][0] - m[0][1];
            end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
                lead = 65536 + m[0][0] - m[1][1] - m[2][2];
                q[0] = m[2][1] - m[1][2];   q[1] = lead;
                q[2] = m[0][1] + m[1][0];   q[3] = m[0][2] + m[2][0];
            end else if (m[1][1] > m[2][2]) begin
                lead = 65536 + m[1][1] - m[0][0] - m[2][2];
                q[0] = m[0][2] - m[2][0];   q[1] = m[0][1] + m[1][0];
                q[2] = lead;                q[3] = m[1][2] + m[2][1];
            end else begin
                lead = 65536 + m[2][2] - m[0][0] - m[1][1];
                q[0] = m[1][0] - m[0][1];   q[1] = m[0][2] + m[2][0];
                q[2] = m[1][2] + m[2][1];   q[3] = lead;
            end
            // a large tolerance can let through a matrix with no usable branch
            if (lead <= 0) ok = 1'b0;
        end
        res.ok = ok;
        res.ts = ts;
        res.w = '0; res.x = '0; res.y = '0; res.z = '0;
        if (ok) begin
            s = 0;
            for (int k = 0; k < 4; k++) s = s + longint'(q[k] * q[k]);
            den = int_sqrt(s << 22);
            if (den == 0) den = 1;
            for (int k = 0; k < 4; k++) begin
                a = q[k] < 0 ? -q[k] : q[k];
                r = ((a << 27) + den / 2) / den;
                if (q[k] < 0) comp = (r > 131072) ? -131072 : -longint'(r);
                else comp = (r > 131071) ? 131071 : longint'(r);
                case (k)
                    0: res.w = elem_t'(comp);
                    1: res.x = elem_t'(comp);
                    2: res.y = elem_t'(comp);
                    default: res.z = elem_t'(comp);
                endcase
            end
        end
        return res;
    endfunction

    function automatic mat_t mat_of(input int e00, e01, e02, e10, e11, e12, e20, e21, e22);
        mat_t mt;
        mt.m00 = elem_t'(e00); mt.m01 = elem_t'(e01); mt.m02 = elem_t'(e02);
        mt.m10 = elem_t'(e10); mt.m11 = elem_t'(e11); mt.m12 = elem_t'(e12);
        mt.m20 = elem_t'(e20); mt.m21 = elem_t'(e21); mt.m22 = elem_t'(e22);
        return mt;
    endfunction

    function automatic void add_row(input mat_t mt, input logic [TsW-1:0] ts, input bit typed,
                                    input bit ok, input int w, x, y, z);
        stim_row_t row;
        row.mat = mt;
        row.ts = ts;
        row.typed = typed;
        row.want.ok = ok;
        row.want.w = elem_t'(w); row.want.x = elem_t'(x);
        row.want.y = elem_t'(y); row.want.z = elem_t'(z);
        row.want.ts = ts;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic elem_t to_q16(input real v);
        int k;
        k = $rtoi(v * 65536.0 + (v >= 0.0 ? 0.5 : -0.5));
        if (k > 131071) k = 131071;
        if (k < -131072) k = -131072;
        return elem_t'(k);
    endfunction

    function automatic mat_t random_rotation();
        real a, b, c, d, n;
        mat_t mt;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        d = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin
            a = 1.0; n = 1.0;
        end
        a = a / n; b = b / n; c = c / n; d = d / n;
        mt.m00 = to_q16(1.0 - 2.0 * (c * c + d * d));
        mt.m01 = to_q16(2.0 * (b * c - a * d));
        mt.m02 = to_q16(2.0 * (b * d + a * c));
        mt.m10 = to_q16(2.0 * (b * c + a * d));
        mt.m11 = to_q16(1.0 - 2.0 * (b * b + d * d));
        mt.m12 = to_q16(2.0 * (c * d - a * b));
        mt.m20 = to_q16(2.0 * (b * d - a * c));
        mt.m21 = to_q16(2.0 * (c * d + a * b));
        mt.m22 = to_q16(1.0 - 2.0 * (b * b + c * c));
        return mt;
    endfunction

    // exact signed permutation with determinant +1, passes even at zero tolerance
    function automatic mat_t random_signed_perm();
        int perms[6][3] = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1},
                            '{0, 2, 1}, '{2, 1, 0}, '{1, 0, 2}};
        int pi, sg[3];
        int e[3][3];
        pi = $urandom_range(0, 5);
        sg[0] = $urandom_range(0, 1) ? 1 : -1;
        sg[1] = $urandom_range(0, 1) ? 1 : -1;
        sg[2] = sg[0] * sg[1] * (pi < 3 ? 1 : -1);
        e = '{default: 0};
        for (int r = 0; r < 3; r++) e[r][perms[pi][r]] = sg[r] * 65536;
        return mat_of(e[0][0], e[0][1], e[0][2], e[1][0], e[1][1], e[1][2],
                      e[2][0], e[2][1], e[2][2]);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_request(input mat_t mt, input logic [TsW-1:0] ts, input bit typed,
                                input res_t want);
        int gap;
        int idle_pct;
        gap = 0;
        idle_pct = 0;
        if (idle_mode == IdleSender) idle_pct = 75;
        if (idle_mode == IdleBoth) idle_pct = 29;
        // geometric gap, idle for about idle_pct percent of the time
        while ($urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(InDataW - TsW - 9 * ElemW){1'b0}}, ts,
                    mt.m22, mt.m21, mt.m20, mt.m12, mt.m11, mt.m10, mt.m02, mt.m01, mt.m00};
        do @(posedge aclk); while (!s_tready);
        pending_quats.insert(pending_quats.size(),
                             typed ? want : predict_quaternion(mt, ts, tol_shadow));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge aclk);
        repeat (LatencyWait) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TolW-1:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_shadow = value;
    endtask

    // receiver side: random stalls plus the long hold-off, counted here
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            m_tready <= 1'b0;
            hold_request <= hold_request - 1;
        end else if (idle_mode == IdleReceiver) begin
            m_tready <= ($urandom_range(0, 99) >= 75);
        end else if (idle_mode == IdleBoth) begin
            m_tready <= ($urandom_range(0, 99) >= 29);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_quats.size() == 0) begin
                report_mismatch("unexpected result, time_out", m_tdata[135:72], 0);
            end else begin
                want = pending_quats.pop_front();
                if (m_tuser !== want.ok) report_mismatch("is_valid", m_tuser, want.ok);
                if (m_tdata[17:0] !== want.w)
                    report_mismatch("quat_w", elem_t'(m_tdata[17:0]), want.w);
                if (m_tdata[35:18] !== want.x)
                    report_mismatch("quat_x", elem_t'(m_tdata[35:18]), want.x);
                if (m_tdata[53:36] !== want.y)
                    report_mismatch("quat_y", elem_t'(m_tdata[53:36]), want.y);
                if (m_tdata[71:54] !== want.z)
                    report_mismatch("quat_z", elem_t'(m_tdata[71:54]), want.z);
                if (m_tdata[135:72] !== want.ts)
                    report_mismatch("time_out", m_tdata[135:72], want.ts);
            end
        end
    end

    initial begin
        logic [TolW-1:0] tol_steps[6];
        mat_t mt;
        res_t none;
        int pick, items;
        tol_steps = '{32'd1 << 20, 32'd0, 32'hFFFF_FFFF, TolReset, 32'd1 << 22, 32'd1 << 18};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_mode = IdleNone;
        hold_request = 0;
        error_count = 0;
        tol_shadow = TolReset;
        none = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(mat_of(65536, 0, 0, 0, 65536, 0, 0, 0, 65536), '0, 1, 1, 65536, 0, 0, 0);
        add_row(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0), '1, 1, 0, 0, 0, 0, 0);
        add_row(mat_of(131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071,
                       131071), 64'h5555_5555_5555_5555, 1, 0, 0, 0, 0, 0);
        add_row(mat_of(-131072, -131072, -131072, -131072, -131072, -131072, -131072,
                       -131072, -131072), 64'hAAAA_AAAA_AAAA_AAAA, 1, 0, 0, 0, 0, 0);
        add_row(mat_of(65536, 0, 0, 0, -65536, 0, 0, 0, -65536), 64'd4, 1, 1, 0, 65536, 0, 0);
        add_row(mat_of(-65536, 0, 0, 0, 65536, 0, 0, 0, -65536), 64'd5, 1, 1, 0, 0, 65536, 0);
        add_row(mat_of(-65536, 0, 0, 0, -65536, 0, 0, 0, 65536), 64'd6, 1, 1, 0, 0, 0, 65536);
        // reflection: unit columns but determinant -1
        add_row(mat_of(-65536, 0, 0, 0, -65536, 0, 0, 0, -65536), 64'd7, 1, 0, 0, 0, 0, 0);
        // one lsb off the identity is outside the reset tolerance
        add_row(mat_of(65537, 0, 0, 0, 65536, 0, 0, 0, 65536), 64'd8, 1, 0, 0, 0, 0, 0);
        add_row(mat_of(0, -65536, 0, 65536, 0, 0, 0, 0, 65536), 64'd9, 0, 0, 0, 0, 0, 0);
        add_row(mat_of(0, 65536, 0, 65536, 0, 0, 0, 0, -65536), 64'd10, 0, 0, 0, 0, 0, 0);
        add_row(mat_of(0, 0, 65536, 65536, 0, 0, 0, 65536, 0), 64'd11, 0, 0, 0, 0, 0, 0);
        add_row(mat_of(65536, 0, 0, 0, 46341, -46341, 0, 46341, 46341), 64'd12, 0, 0, 0, 0, 0, 0);
        add_row(mat_of(-32768, 0, 0, 0, -32768, 0, 0, 0, 32768), 64'd13, 0, 0, 0, 0, 0, 0);
        foreach (stim_rows[i])
            send_request(stim_rows[i].mat, stim_rows[i].ts, stim_rows[i].typed, stim_rows[i].want);

        // near-degenerate diagonals only pass at the widest tolerance
        write_tolerance(32'hFFFF_FFFF);
        send_request(mat_of(-32768, 0, 0, 0, -32768, 0, 0, 0, 32768), 64'd14, 0, none);
        send_request(mat_of(92681, 0, 0, 0, -46341, 0, 0, 0, -60000), 64'd15, 0, none);
        send_request(mat_of(-40000, 0, 0, 0, 70000, 0, 0, 0, -80000), 64'd16, 0, none);

        items = 0;
        for (int ph = 0; ph < Phases; ph++) begin
            write_tolerance(tol_steps[ph % 6]);
            idle_mode = idle_mode_t'(ph % 4);
            // phase is longer than the pipeline, so the hold-off backs up the input
            if (ph == 0) hold_request = 400;
            for (int k = 0; k < RandomItems / Phases; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    mt = random_rotation();
                end else if (pick < 75) begin
                    mt = random_signed_perm();
                end else if (pick < 85) begin
                    mt = random_rotation();
                    mt.m11 = mt.m11 + elem_t'($urandom_range(0, 4000)) - elem_t'(2000);
                end else begin
                    mt = mat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                end
                send_request(mt, {$urandom, $urandom}, 0, none);
                items++;
                // sender waits once for the pipeline to empty mid phase
                if (ph == 1 && k == 20) begin
                    s_tvalid <= 1'b0;
                    while (pending_quats.size() != 0) @(posedge aclk);
                end
            end
        end
        idle_mode = IdleNone;
        drain_pipeline();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/rmq_pkg.sv
sv/rmq_check.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
sim/tb.sv
